// ===== hw/rtl/i8601_pkg.sv =====
// Shared types and constants for the timestamp-to-epoch block.
// Used by i8601_front, i8601_queue, i8601_calc and the top level.
package i8601_pkg;

  // Default depth of the queue between the character checker and the date unit.
  localparam int QUEUE_DEPTH_DEF = 2;

  // One closed timestamp: the accumulated fields and the format verdict.
  typedef struct packed {
    logic        fmt_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  sec;
  } ts_ent_t;

endpackage

// ===== hw/rtl/i8601_front.sv =====
// Character checker: validates each character of YYYY-MM-DDTHH:MM:SSZ by position
// and accumulates the decimal fields. Depends on i8601_pkg.
module i8601_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_ch,
  input  logic              in_last,
  output logic              push,
  output i8601_pkg::ts_ent_t push_ent,
  input  logic              q_full
);
  import i8601_pkg::*;

  // Separator positions and the full string length.
  localparam logic [4:0] POS_DASH_A  = 5'd4;
  localparam logic [4:0] POS_DASH_B  = 5'd7;
  localparam logic [4:0] POS_T       = 5'd10;
  localparam logic [4:0] POS_COLON_A = 5'd13;
  localparam logic [4:0] POS_COLON_B = 5'd16;
  localparam logic [4:0] POS_Z       = 5'd19;
  localparam logic [4:0] TS_LEN      = 5'd20;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic        err_r, err_nxt;
  logic        bad;
  logic        is_digit;
  logic [3:0]  dig;
  logic        accept;

  // Decimal accumulate, wrapping at the register width.
  function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
    return 7'({a, 3'b000}) + 7'({a, 1'b0}) + 7'(d);
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
    return 14'({a, 3'b000}) + 14'({a, 1'b0}) + 14'(d);
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign dig      = in_ch[3:0];

  // Position check and field accumulation for the current character.
  always_comb begin
    bad        = 1'b0;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    sec_nxt    = sec_r;
    priority if (pos_r >= TS_LEN) begin
      bad = 1'b1;
    end else if (pos_r == POS_DASH_A || pos_r == POS_DASH_B) begin
      bad = (in_ch != CH_DASH);
    end else if (pos_r == POS_T) begin
      bad = (in_ch != CH_T);
    end else if (pos_r == POS_COLON_A || pos_r == POS_COLON_B) begin
      bad = (in_ch != CH_COLON);
    end else if (pos_r == POS_Z) begin
      bad = (in_ch != CH_Z);
    end else if (!is_digit) begin
      bad = 1'b1;
    end else if (pos_r < POS_DASH_A) begin
      year_nxt = acc14(year_r, dig);
    end else if (pos_r < POS_DASH_B) begin
      month_nxt = acc7(month_r, dig);
    end else if (pos_r < POS_T) begin
      day_nxt = acc7(day_r, dig);
    end else if (pos_r < POS_COLON_A) begin
      hour_nxt = acc7(hour_r, dig);
    end else if (pos_r < POS_COLON_B) begin
      minute_nxt = acc7(minute_r, dig);
    end else begin
      sec_nxt = acc7(sec_r, dig);
    end
    err_nxt = err_r | bad;
    pos_nxt = (pos_r < TS_LEN) ? pos_r + 5'd1 : pos_r;
  end

  // The last character closes the string and hands it to the queue.
  assign push            = accept && in_last;
  assign push_ent.fmt_ok = !err_nxt && (pos_r == POS_Z);
  assign push_ent.year   = year_nxt;
  assign push_ent.month  = month_nxt;
  assign push_ent.day    = day_nxt;
  assign push_ent.hour   = hour_nxt;
  assign push_ent.minute = minute_nxt;
  assign push_ent.sec    = sec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      sec_r    <= '0;
      err_r    <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      sec_r    <= sec_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== hw/rtl/i8601_queue.sv =====
// Small register queue of closed timestamps between checker and date unit.
// Depends on i8601_pkg; DEPTH must be at least 2.
module i8601_queue #(
  parameter int DEPTH = i8601_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i8601_pkg::ts_ent_t push_ent,
  output logic               full,
  input  logic               pop,
  output i8601_pkg::ts_ent_t pop_ent,
  output logic               empty
);
  import i8601_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ts_ent_t           ent_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_ent = ent_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/i8601_calc.sv =====
// Date unit: range checks and civil date to day count, seconds and weekday,
// as a five-step sequencer with an output register. Depends on i8601_pkg.
module i8601_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  i8601_pkg::ts_ent_t pop_ent,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic signed [38:0] out_epoch_seconds,
  output logic [4:0]         out_hour_of_day,
  output logic [2:0]         out_weekday
);
  import i8601_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_DAYS,
    ST_OUT
  } state_t;

  // Reciprocal of 25 scaled by 2^16; exact for quotients of values below 4096.
  localparam logic [11:0] RECIP_25   = 12'd2622;
  // Day count of the year offset by one era, minus that offset, gives epoch days.
  localparam logic [23:0] DAY_BIAS   = 24'd865565;
  localparam logic [13:0] ERA_YEARS  = 14'd400;
  localparam logic [22:0] DAYS_YEAR  = 23'd365;
  localparam logic [16:0] SECS_HOUR  = 17'd3600;
  localparam logic [16:0] SECS_MIN   = 17'd60;
  localparam logic [14:0] YEARS_CENT = 15'd100;
  localparam logic [6:0]  MONTH_FEB  = 7'd2;
  localparam logic [6:0]  MONTH_DEC  = 7'd12;
  localparam logic [6:0]  HOUR_MAX   = 7'd23;
  localparam logic [6:0]  MINSEC_MAX = 7'd59;
  localparam logic signed [40:0] SECS_DAY = 41'sd86400;

  state_t              state_r;
  ts_ent_t             ent_r;
  logic [13:0]         y2_r;
  logic [3:0]          mp_r;
  logic [7:0]          c100_r;
  logic [7:0]          yc_r;
  logic [22:0]         y365_r;
  logic [16:0]         tod_r;
  logic [8:0]          doy_r;
  logic [22:0]         raw_r;
  logic                good_r;
  logic signed [23:0]  days_r;
  logic [2:0]          wd_r;
  logic                out_valid_r;
  logic                res_r;
  logic signed [38:0]  epoch_r;
  logic [4:0]          hour_out_r;
  logic [2:0]          wd_out_r;

  logic                early;
  logic [23:0]         c100_prod;
  logic [23:0]         yc_prod;
  logic                leap;
  logic [6:0]          mlen;
  logic                range_ok;
  logic signed [40:0]  secs_full;
  logic                load_out;

  // Days before the first of a month, counting from March.
  function automatic logic [8:0] doy_base(input logic [3:0] mp);
    logic [8:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Residue mod 7 by folding octal digits, since 8 is 1 mod 7.
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(x[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

  assign pop   = (state_r == ST_IDLE) && !empty;
  assign early = (pop_ent.month <= MONTH_FEB);

  // The output register takes a new result when it is free or being emptied.
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Century quotients of the shifted year and of the calendar year.
  assign c100_prod = {12'b0, y2_r[13:2]} * {12'b0, RECIP_25};
  assign yc_prod   = {12'b0, ent_r.year[13:2]} * {12'b0, RECIP_25};

  // Gregorian leap rule and month length.
  assign leap = (ent_r.year[1:0] == 2'b00) &&
                ((15'(yc_r) * YEARS_CENT != {1'b0, ent_r.year}) || (yc_r[1:0] == 2'b00));

  always_comb begin
    unique case (ent_r.month)
      7'd4, 7'd6, 7'd9, 7'd11: mlen = 7'd30;
      MONTH_FEB:               mlen = leap ? 7'd29 : 7'd28;
      default:                 mlen = 7'd31;
    endcase
  end

  assign range_ok = (ent_r.month >= 7'd1) && (ent_r.month <= MONTH_DEC) &&
                    (ent_r.day >= 7'd1) && (ent_r.day <= mlen) &&
                    (ent_r.hour <= HOUR_MAX) && (ent_r.minute <= MINSEC_MAX) &&
                    (ent_r.sec <= MINSEC_MAX);

  assign secs_full = $signed({{17{days_r[23]}}, days_r}) * SECS_DAY;

  // Sequencer, working registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            ent_r   <= pop_ent;
            y2_r    <= pop_ent.year + ERA_YEARS - {13'b0, early};
            mp_r    <= early ? 4'(pop_ent.month + 7'd9) : 4'(pop_ent.month - 7'd3);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          c100_r  <= c100_prod[23:16];
          yc_r    <= yc_prod[23:16];
          y365_r  <= 23'(y2_r) * DAYS_YEAR;
          tod_r   <= 17'(ent_r.hour) * SECS_HOUR + 17'(ent_r.minute) * SECS_MIN +
                     17'(ent_r.sec);
          doy_r   <= doy_base(mp_r) + 9'(ent_r.day) - 9'd1;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          raw_r   <= y365_r + 23'(y2_r[13:2]) - 23'(c100_r) + 23'(c100_r[7:2]) +
                     23'(doy_r);
          good_r  <= ent_r.fmt_ok && range_ok;
          state_r <= ST_DAYS;
        end
        ST_DAYS: begin
          days_r  <= $signed({1'b0, raw_r} - DAY_BIAS);
          wd_r    <= mod7({1'b0, raw_r} + 24'd2);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            res_r       <= good_r;
            epoch_r     <= good_r ? $signed(secs_full[38:0] + {22'b0, tod_r}) : '0;
            hour_out_r  <= good_r ? ent_r.hour[4:0] : '0;
            wd_out_r    <= good_r ? wd_r : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = res_r;
  assign out_epoch_seconds = epoch_r;
  assign out_hour_of_day   = hour_out_r;
  assign out_weekday       = wd_out_r;

endmodule

// ===== hw/rtl/iso8601_timestamp_to_epoch.sv =====
// Top level: UTC timestamp text YYYY-MM-DDTHH:MM:SSZ to signed Unix seconds.
// Depends on i8601_pkg, i8601_front, i8601_queue and i8601_calc.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   in_ch[7:0], in_last
//   output   out_valid / out_stall out_valid_res, out_epoch_seconds[38:0],
//                                  out_hour_of_day[4:0], out_weekday[2:0]
//
// Characters are taken one per cycle; the checker stalls only when the queue is full.
// Each closed string passes through the sequencer states ST_DIV, ST_SUM, ST_DAYS and
// ST_OUT of the date unit; a new string is popped from the queue only in ST_IDLE, so
// the date unit takes no new string before the last result is in its output register.
// Reset is synchronous and active low; it clears the position, error flag,
// queue pointers, sequencer state and output valid.
// A stalled result holds in the output register while the checker keeps working until the queue is full.
module iso8601_timestamp_to_epoch #(
  parameter int QUEUE_DEPTH = i8601_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic signed [38:0] out_epoch_seconds,
  output logic [4:0]         out_hour_of_day,
  output logic [2:0]         out_weekday
);
  import i8601_pkg::*;

  logic    push;
  ts_ent_t push_ent;
  logic    q_full;
  logic    pop;
  ts_ent_t pop_ent;
  logic    q_empty;

  i8601_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .push     (push),
    .push_ent (push_ent),
    .q_full   (q_full)
  );

  i8601_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .pop_ent  (pop_ent),
    .empty    (q_empty)
  );

  i8601_calc u_calc (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_ent           (pop_ent),
    .empty             (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_valid_res     (out_valid_res),
    .out_epoch_seconds (out_epoch_seconds),
    .out_hour_of_day   (out_hour_of_day),
    .out_weekday       (out_weekday)
  );

endmodule
